FILE: hdl/ipv4_fragment_planner_unit_defines.svh
// assertion helpers for the fragment planner
`ifndef IPV4_FRAGMENT_PLANNER_UNIT_DEFINES_SVH
`define IPV4_FRAGMENT_PLANNER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define IFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IFP_ASSERT(label, prop, msg)
`define IFP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: hdl/ipv4fp_pkg.sv
package ipv4fp_pkg;

  localparam int CSUM_W        = 16;
  localparam int HDR_W         = 160;
  localparam int OUT_DATA_W    = 64;
  localparam int MAX_FRAGS_DEF = 64;

  localparam logic [15:0] MTU_RESET  = 16'd1500;
  localparam logic [15:0] MIN_HDR_B  = 16'd20;
  localparam int          MF_BIT_POS = 13;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_MTU_SMALL = 2'd2;
  localparam logic [1:0] ST_BELOW_HDR = 2'd3;

endpackage

FILE: hdl/ipv4fp_oc_add.sv
module ipv4fp_oc_add
  import ipv4fp_pkg::*;
(
  input  logic [CSUM_W-1:0] a,
  input  logic [CSUM_W-1:0] b,
  output logic [CSUM_W-1:0] s
);

  logic [CSUM_W:0] raw;

  // ones' complement add, carry wraps round into bit 0
  assign raw = {1'b0, a} + {1'b0, b};
  assign s   = raw[CSUM_W-1:0] + CSUM_W'(raw[CSUM_W]);

endmodule

FILE: hdl/ipv4_fragment_planner_unit.sv
// channel | ports                       | contents
// in      | in_tvalid/tready/tdata      | one ipv4 base header plus total length
// out     | out_tvalid/tready/tdata/... | one fragment descriptor per transfer
// cfg     | cfg_wr_en/cfg_wr_data       | mtu in bytes, header included
//
// a packet is set up by accept, checks and 7 adds into the header sum,
// then each fragment takes two passes through the shared ones' complement
// adder and an output step, stretched by any out_tready stall.
// error and pass-through packets go through accept, checks and the output step only.
// in_tready is high only while no packet is in work; reset sets mtu to 1500.
`include "ipv4_fragment_planner_unit_defines.svh"

module ipv4_fragment_planner_unit
  import ipv4fp_pkg::*;
#(
  parameter int MAX_FRAGS = MAX_FRAGS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // version_and_length, service_type, packet_length, ident, orig_flags_offset,
  // hop_limit, protocol, orig_checksum, source_address, dest_address
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [HDR_W-1:0]      in_tdata,
  // frag_offset, frag_length, more_frags, frag_flags_offset,
  // header_checksum, 2 bits zero padding
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_FRAGS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_BASE, S_FRAG, S_SUM, S_OUT
  } state_t;

  state_t                 state_r;
  logic [HDR_W-1:0]       hdr_r;
  logic [15:0]            mtu_r;
  logic [15:0]            maxp_r;
  logic [15:0]            remain_r;
  logic [15:0]            offset_r;
  logic [15:0]            chunk_r;
  logic [15:0]            flen_r;
  logic [15:0]            fo_r;
  logic                   mf_r;
  logic [2:0]             widx_r;
  logic [CNT_W-1:0]       count_r;
  logic [CSUM_W-1:0]      base_r;
  logic [CSUM_W-1:0]      sum_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [1:0]             out_status_r;
  logic                   out_last_r;

  logic [7:0]  vl;
  logic [15:0] plen;
  logic [15:0] ofo;
  logic [15:0] ock;
  logic [5:0]  hlen;
  logic [15:0] hlen16;
  logic [15:0] mtu_room;
  logic [15:0] maxp;
  logic [15:0] word;
  logic [15:0] chunk;
  logic        mf;
  logic [15:0] flen;
  logic        fin;
  logic [CSUM_W-1:0] add_a;
  logic [CSUM_W-1:0] add_b;
  logic [CSUM_W-1:0] add_s;

  assign vl     = hdr_r[7:0];
  assign plen   = hdr_r[31:16];
  assign ofo    = hdr_r[63:48];
  assign ock    = hdr_r[95:80];
  assign hlen   = {vl[3:0], 2'b00};
  assign hlen16 = {10'd0, hlen};

  assign mtu_room = mtu_r - hlen16;
  assign maxp     = (mtu_r > hlen16) ? (mtu_room & 16'hFFF8) : 16'd0;

  // header words in network byte order
  always_comb begin
    unique case (widx_r)
      3'd0:    word = {hdr_r[7:0], hdr_r[15:8]};
      3'd1:    word = hdr_r[47:32];
      3'd2:    word = {hdr_r[71:64], hdr_r[79:72]};
      3'd3:    word = hdr_r[127:112];
      3'd4:    word = hdr_r[111:96];
      3'd5:    word = hdr_r[159:144];
      default: word = hdr_r[143:128];
    endcase
  end

  assign mf    = remain_r > maxp_r;
  assign chunk = mf ? maxp_r : remain_r;
  assign flen  = hlen16 + chunk;
  assign fin   = !mf_r || (count_r == CNT_W'(MAX_FRAGS - 1));

  // operand selection for the one shared adder
  always_comb begin
    priority case (state_r)
      S_BASE: begin
        add_a = base_r;
        add_b = word;
      end
      S_FRAG: begin
        add_a = base_r;
        add_b = flen;
      end
      default: begin
        add_a = sum_r;
        add_b = fo_r;
      end
    endcase
  end

  ipv4fp_oc_add u_add (
    .a (add_a),
    .b (add_b),
    .s (add_s)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mtu_r       <= MTU_RESET;
      widx_r      <= 3'd0;
      count_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        mtu_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            hdr_r   <= in_tdata;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          out_last_r   <= 1'b1;
          remain_r     <= plen - hlen16;
          maxp_r       <= maxp;
          offset_r     <= '0;
          count_r      <= '0;
          widx_r       <= 3'd0;
          base_r       <= '0;
          if (plen < MIN_HDR_B) begin
            out_data_r   <= '0;
            out_status_r <= ST_SHORT;
            out_valid_r  <= 1'b1;
            state_r      <= S_OUT;
          end else if (plen < hlen16) begin
            out_data_r   <= '0;
            out_status_r <= ST_BELOW_HDR;
            out_valid_r  <= 1'b1;
            state_r      <= S_OUT;
          end else if (plen == hlen16) begin
            // no payload: header goes through untouched
            out_data_r   <= {2'b00, ock, ofo, 1'b0, plen, 13'd0};
            out_status_r <= ST_OK;
            out_valid_r  <= 1'b1;
            state_r      <= S_OUT;
          end else if (maxp == 16'd0) begin
            out_data_r   <= '0;
            out_status_r <= ST_MTU_SMALL;
            out_valid_r  <= 1'b1;
            state_r      <= S_OUT;
          end else begin
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          base_r <= add_s;
          widx_r <= widx_r + 3'd1;
          if (widx_r == 3'd6) begin
            state_r <= S_FRAG;
          end
        end
        S_FRAG: begin
          sum_r   <= add_s;
          chunk_r <= chunk;
          flen_r  <= flen;
          mf_r    <= mf;
          fo_r    <= {2'b00, mf, offset_r[15:3]};
          state_r <= S_SUM;
        end
        S_SUM: begin
          out_data_r   <= {2'b00, ~add_s, fo_r, mf_r, flen_r, offset_r[15:3]};
          out_status_r <= ST_OK;
          out_last_r   <= fin;
          out_valid_r  <= 1'b1;
          state_r      <= S_OUT;
        end
        default: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            offset_r    <= offset_r + chunk_r;
            remain_r    <= remain_r - chunk_r;
            count_r     <= count_r + CNT_W'(1);
            state_r     <= out_last_r ? S_IDLE : S_FRAG;
          end
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  `IFP_ASSERT(a_one_side_busy, !(in_tready && out_tvalid), "input taken while result pending")
  `IFP_ASSERT(a_err_is_last, !out_tvalid || out_tuser == ST_OK || out_tlast,
    "error descriptor not marked last")
  `IFP_ASSERT(a_final_is_last, !out_tvalid || out_tdata[29] || out_tlast,
    "descriptor without more fragments not marked last")
  `IFP_ASSERT_NEXT(a_back_to_idle, out_tvalid && out_tready && out_tlast, in_tready,
    "not ready after final descriptor")

endmodule

FILE: test/ipv4_fragment_planner_unit_tb.sv
`timescale 1ns / 1ps

module ipv4_fragment_planner_unit_tb;
  import ipv4fp_pkg::*;

  localparam int FRAG_LIMIT     = MAX_FRAGS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [7:0]  ver_ihl;
    logic [7:0]  tos;
    logic [15:0] total_len;
    logic [15:0] ident;
    logic [15:0] flags_off;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [15:0] csum;
    logic [31:0] src;
    logic [31:0] dst;
  } ip_hdr_t;

  typedef struct {
    logic [1:0]  status;
    logic [12:0] offset;
    logic [15:0] length;
    logic        mf;
    logic [15:0] flags_offset;
    logic [15:0] checksum;
    logic        last;
  } frag_desc_t;

  typedef enum {RX_STEADY, RX_PATTERN, RX_HOLDOFF} rx_style_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  // version_and_length, service_type, packet_length, ident, orig_flags_offset,
  // hop_limit, protocol, orig_checksum, source_address, dest_address
  logic [HDR_W-1:0]      in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  // frag_offset, frag_length, more_frags, frag_flags_offset,
  // header_checksum, 2 bits zero padding
  logic [OUT_DATA_W-1:0] out_tdata;
  // status
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en   = 1'b0;
  logic [15:0]           cfg_wr_data = '0;

  frag_desc_t  pending_frags [$];
  logic [15:0] planner_mtu = MTU_RESET;

  int unsigned mismatches   = 0;
  int unsigned packets_sent = 0;
  int unsigned descs_seen   = 0;
  int unsigned mtu_writes   = 0;
  int unsigned status_seen [4];
  int unsigned quiet_cycles = 0;

  int unsigned burst_left  = 0;
  bit          sender_gaps = 1'b1;
  rx_style_t   rx_style    = RX_STEADY;
  logic [15:0] rx_pattern  = 16'b1011_0110_1110_0101;
  int unsigned hold_left   = 0;

  ipv4_fragment_planner_unit #(
    .MAX_FRAGS(FRAG_LIMIT)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("descriptor %0d %s: got 0x%0h, expected 0x%0h",
                                descs_seen, name, got, want));
  endtask

  // works out the descriptors one accepted packet must produce
  task automatic plan_fragments(input ip_hdr_t h);
    int unsigned hlen, payload, maxp, offset, chunk, count;
    logic [31:0] sum;
    frag_desc_t  d;
    hlen = 4 * h.ver_ihl[3:0];
    d = '{default: '0};
    d.last = 1'b1;
    if (h.total_len < MIN_HDR_B) begin
      d.status = ST_SHORT;
      pending_frags.push_back(d);
      return;
    end
    if (h.total_len < hlen) begin
      d.status = ST_BELOW_HDR;
      pending_frags.push_back(d);
      return;
    end
    payload = h.total_len - hlen;
    // header only: passed through untouched, mtu not looked at
    if (payload == 0) begin
      d.length       = h.total_len;
      d.flags_offset = h.flags_off;
      d.checksum     = h.csum;
      pending_frags.push_back(d);
      return;
    end
    maxp = (planner_mtu > hlen) ? ((planner_mtu - hlen) / 8) * 8 : 0;
    if (maxp == 0) begin
      d.status = ST_MTU_SMALL;
      pending_frags.push_back(d);
      return;
    end
    offset = 0;
    count  = 0;
    while (offset < payload && count < FRAG_LIMIT) begin
      chunk          = (payload - offset > maxp) ? maxp : payload - offset;
      d.offset       = 13'(offset / 8);
      d.length       = 16'(hlen + chunk);
      d.mf           = (offset + chunk < payload);
      d.flags_offset = 16'(d.offset);
      d.flags_offset[MF_BIT_POS] = d.mf;
      // base header summed in network order, checksum word as zero
      sum = {h.ver_ihl, h.tos} + d.length + h.ident + d.flags_offset + {h.ttl, h.proto}
          + h.src[31:16] + h.src[15:0] + h.dst[31:16] + h.dst[15:0];
      while (sum[31:16] != 0) sum = sum[15:0] + sum[31:16];
      d.checksum = ~sum[15:0];
      // the cap forces last even while payload remains
      d.last     = !d.mf || (count + 1 >= FRAG_LIMIT);
      pending_frags.push_back(d);
      offset += chunk;
      count++;
    end
  endtask

  function automatic ip_hdr_t make_header(input logic [7:0] vl, input logic [15:0] plen);
    ip_hdr_t h;
    h.ver_ihl   = vl;
    h.total_len = plen;
    h.tos       = 8'($urandom);
    h.ident     = 16'($urandom);
    h.flags_off = 16'($urandom);
    h.ttl       = 8'($urandom);
    h.proto     = 8'($urandom);
    h.csum      = 16'($urandom);
    h.src       = $urandom;
    h.dst       = $urandom;
    return h;
  endfunction

  task automatic send_packet(input ip_hdr_t h);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (sender_gaps) begin
        in_tvalid <= 1'b0;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4))
          @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {h.dst, h.src, h.csum, h.proto, h.ttl, h.flags_off, h.ident,
                  h.total_len, h.tos, h.ver_ihl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    plan_fragments(h);
    packets_sent++;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_frags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mtu(input logic [15:0] value);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    planner_mtu = value;
    mtu_writes++;
  endtask

  task automatic test_error_cases();
    rx_style = RX_PATTERN;
    send_packet(make_header(8'h45, 16'd0));
    send_packet(make_header(8'h45, 16'd19));
    // 60-byte header longer than the packet
    send_packet(make_header(8'h4F, 16'd40));
    send_packet(make_header(8'h4F, 16'd59));
    // header only
    send_packet(make_header(8'h45, 16'd20));
    send_packet(make_header(8'h4F, 16'd60));
    // header length under five words taken as given
    send_packet(make_header(8'h40, 16'd20));
    send_packet(make_header(8'h43, 16'd100));
  endtask

  task automatic test_header_extremes();
    ip_hdr_t h;
    h = '{default: '1};
    send_packet(h);
    h = '{default: '0};
    send_packet(h);
    h.ver_ihl   = 8'h05;
    h.total_len = 16'd20;
    send_packet(h);
  endtask

  task automatic test_mtu_limits();
    rx_style = RX_HOLDOFF;
    set_mtu(16'd0);
    send_packet(make_header(8'h45, 16'd100));
    send_packet(make_header(8'h45, 16'd20));
    // mtu equal to the header
    set_mtu(16'd20);
    send_packet(make_header(8'h45, 16'd100));
    // room under one 8-byte unit rounds to nothing
    set_mtu(16'd27);
    send_packet(make_header(8'h45, 16'd100));
    set_mtu(16'hFFFF);
    send_packet(make_header(8'h45, 16'hFFFF));
    // second fragment lands on the top offset
    send_packet(make_header(8'h40, 16'hFFFF));
  endtask

  task automatic test_fragment_limit();
    rx_style = RX_STEADY;
    set_mtu(16'd28);
    send_packet(make_header(8'h45, 16'd532));
    send_packet(make_header(8'h45, 16'd540));
    send_packet(make_header(8'h45, 16'd525));
    send_packet(make_header(8'h45, 16'hFFFF));
  endtask

  task automatic test_random_traffic();
    logic [15:0] mtu_plan [8] = '{16'd576, 16'd68, 16'd1500, 16'd28, 16'd1006, 16'hFFFF,
                                  16'd0, 16'd21};
    int unsigned pick, hlen, maxp, span;
    logic [7:0]  vl;
    logic [15:0] plen;
    for (int p = 0; p < 10; p++) begin
      set_mtu((p < 8) ? mtu_plan[p] : 16'($urandom_range(21, 2000)));
      rx_style    = rx_style_t'(p % 3);
      sender_gaps = (p % 4 != 1);
      for (int i = 0; i < 20; i++) begin
        pick = $urandom_range(0, 99);
        vl   = (pick < 60) ? 8'h45 : {4'd4, 4'($urandom_range(5, 15))};
        hlen = 4 * vl[3:0];
        maxp = (planner_mtu > hlen) ? ((planner_mtu - hlen) / 8) * 8 : 0;
        // mostly a handful of fragments, now and then a long run
        span = (maxp == 0) ? 600 : maxp * $urandom_range(1, 12);
        if (span > 65535 - hlen) span = 65535 - hlen;
        plen = 16'(hlen + $urandom_range(1, span));
        if (pick >= 85) begin
          vl   = 8'($urandom_range(0, 255));
          plen = pick[0] ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 80));
        end else if (pick >= 78) begin
          plen = 16'(hlen);
        end
        send_packet(make_header(vl, plen));
        if (i == 11 && p % 2 == 0) wait_for_drain();
      end
    end
  endtask

  always @(posedge clk) begin
    case (rx_style)
      RX_STEADY: out_tready <= 1'b1;
      RX_PATTERN: begin
        out_tready <= rx_pattern[0];
        rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
      end
      default: begin
        if (hold_left != 0) begin
          out_tready <= 1'b0;
          hold_left  <= hold_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          out_tready <= 1'b0;
          hold_left  <= $urandom_range(1, 15);
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin : check_descriptors
    frag_desc_t want;
    if (rst_n && out_tvalid && out_tready) begin
      descs_seen++;
      status_seen[out_tuser]++;
      if (pending_frags.size() == 0) begin
        report_mismatch($sformatf("descriptor %0d arrived with none pending", descs_seen));
      end else begin
        want = pending_frags.pop_front();
        check_field("status", 32'(out_tuser), 32'(want.status));
        check_field("frag_offset", 32'(out_tdata[12:0]), 32'(want.offset));
        check_field("frag_length", 32'(out_tdata[28:13]), 32'(want.length));
        check_field("more_frags", 32'(out_tdata[29]), 32'(want.mf));
        check_field("frag_flags_offset", 32'(out_tdata[45:30]), 32'(want.flags_offset));
        check_field("header_checksum", 32'(out_tdata[61:46]), 32'(want.checksum));
        check_field("last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  // counts cycles without any transfer on any port
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: %0d idle cycles, %0d descriptors still pending",
               quiet_cycles, pending_frags.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_error_cases();
    test_header_extremes();
    test_mtu_limits();
    test_fragment_limit();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (pending_frags.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("run covered %0d packets under %0d mtu settings, %0d descriptors checked",
             packets_sent, mtu_writes + 1, descs_seen);
    $display("descriptor status seen: %0d ok, %0d short, %0d mtu too small, %0d below header",
             status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_MTU_SMALL],
             status_seen[ST_BELOW_HDR]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
